[design/cra_pkg.sv]
// ----------------------------------------------------------------------------
// cra_pkg: shared types and constants for the contiguous ring allocator.
// Holds the request and result payload types, operation codes, the
// controller state type and the command bundle from controller to datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package cra_pkg;

  // Default ring capacity in bytes.
  localparam int MAX_BYTES_DEF = 65536;

  // Fixed field widths of the request and result payloads.
  localparam int FUNC_W = 2;
  localparam int LEN_W  = 17;
  localparam int ROFF_W = 16;
  localparam int SUM_W  = 32;

  // Operation codes. Code 3 has no meaning and changes nothing.
  localparam logic [FUNC_W-1:0] FUNC_RESERVE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FETCH   = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [LEN_W-1:0]  length;
  } in_t;

  typedef struct packed {
    logic              granted;
    logic [ROFF_W-1:0] region_offset;
    logic [LEN_W-1:0]  chunk_length;
    logic [LEN_W-1:0]  used_bytes;
    logic [SUM_W-1:0]  total_reserved;
  } out_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } ctrl_cmd_t;

endpackage

`default_nettype wire

[design/cra_ctrl.sv]
// ----------------------------------------------------------------------------
// cra_ctrl: request sequencer for the contiguous ring allocator.
// Captures a request when idle, then executes it in the EXEC state.
// ----------------------------------------------------------------------------
`default_nettype none

module cra_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  output cra_pkg::ctrl_cmd_t      cmd
);

  cra_pkg::state_t state_r;
  cra_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cra_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    busy        = 1'b0;
    unique case (state_r)
      cra_pkg::ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = cra_pkg::ST_EXEC;
        end
      end
      cra_pkg::ST_EXEC: begin
        busy        = 1'b1;
        cmd.execute = 1'b1;
        state_nxt   = cra_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = cra_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[design/cra_datapath.sv]
// ----------------------------------------------------------------------------
// cra_datapath: offset bookkeeping registers of the contiguous ring allocator.
// Holds size, used count, write/read/wrap offsets and the reserved total,
// and computes one request per execute command.
// ----------------------------------------------------------------------------
`default_nettype none

module cra_datapath #(
  parameter int MAX_BYTES = cra_pkg::MAX_BYTES_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire cra_pkg::ctrl_cmd_t        cmd,
  input  wire cra_pkg::in_t              in_data,
  input  wire logic                      cfg_wr_en,
  input  wire logic [cra_pkg::LEN_W-1:0] cfg_wr_data,
  output logic                           out_valid,
  output cra_pkg::out_t                  out_data
);

  localparam int SZ_W  = $clog2(MAX_BYTES + 1);
  localparam int OFF_W = $clog2(MAX_BYTES);
  // Compare width: holds used plus length without overflow.
  localparam int CW    = ((SZ_W > cra_pkg::LEN_W) ? SZ_W : cra_pkg::LEN_W) + 1;

  logic [SZ_W-1:0]          size_r;
  logic [SZ_W-1:0]          used_r,   used_nxt;
  logic [OFF_W-1:0]         wr_off_r, wr_off_nxt;
  logic [OFF_W-1:0]         rd_off_r, rd_off_nxt;
  logic [OFF_W-1:0]         wrap_r,   wrap_nxt;
  logic [cra_pkg::SUM_W-1:0] sum_r,   sum_nxt;
  cra_pkg::in_t             op_r;
  logic                     out_valid_r;
  cra_pkg::out_t            out_r,    out_nxt;

  logic [CW-1:0] cfg_x, cfg_size;
  logic [CW-1:0] size_x, end_x, used_x, len_x, wr_x, rd_x, wrap_x;
  logic [CW-1:0] rd_a, wrap_a, avail, want, chunk, offset;
  logic          fits, tail_ok, granted;

  // Clamp a written size into the supported range.
  always_comb begin
    cfg_x = CW'(cfg_wr_data);
    if (cfg_x < CW'(2)) begin
      cfg_size = CW'(2);
    end else if (cfg_x > CW'(MAX_BYTES)) begin
      cfg_size = CW'(MAX_BYTES);
    end else begin
      cfg_size = cfg_x;
    end
  end

  always_comb begin
    size_x = CW'(size_r);
    end_x  = size_x - CW'(1);
    used_x = CW'(used_r);
    len_x  = CW'(op_r.length);
    wr_x   = CW'(wr_off_r);
    rd_x   = CW'(rd_off_r);
    wrap_x = CW'(wrap_r);

    fits    = (used_x + len_x) <= size_x;
    tail_ok = (wr_x <= end_x) && ((end_x - wr_x) >= len_x);

    // Fetch restarts at offset 0 once the read side reaches the wrap point.
    if (rd_x >= wrap_x) begin
      rd_a   = '0;
      wrap_a = end_x;
    end else begin
      rd_a   = rd_x;
      wrap_a = wrap_x;
    end
    avail = wrap_a - rd_a;
    want  = (used_x > len_x) ? len_x : used_x;
    chunk = (avail >= want) ? want : avail;

    used_nxt   = used_r;
    wr_off_nxt = wr_off_r;
    rd_off_nxt = rd_off_r;
    wrap_nxt   = wrap_r;
    sum_nxt    = sum_r;
    granted    = 1'b0;
    offset     = '0;
    out_nxt.chunk_length = '0;

    unique case (op_r.func)
      cra_pkg::FUNC_RESERVE: begin
        if (fits) begin
          granted  = 1'b1;
          used_nxt = SZ_W'(used_x + len_x);
          sum_nxt  = sum_r + cra_pkg::SUM_W'(op_r.length);
          if (tail_ok) begin
            offset     = wr_x;
            wr_off_nxt = OFF_W'(wr_x + len_x);
          end else begin
            wrap_nxt   = wr_off_r;
            wr_off_nxt = (len_x >= size_x) ? '0 : OFF_W'(len_x);
          end
        end
      end
      cra_pkg::FUNC_RELEASE: begin
        used_nxt = (len_x >= used_x) ? '0 : SZ_W'(used_x - len_x);
      end
      cra_pkg::FUNC_FETCH: begin
        wrap_nxt   = OFF_W'(wrap_a);
        rd_off_nxt = OFF_W'(rd_a);
        if (used_x != '0) begin
          granted              = 1'b1;
          offset               = rd_a;
          rd_off_nxt           = OFF_W'(rd_a + chunk);
          out_nxt.chunk_length = cra_pkg::LEN_W'(chunk);
        end
      end
      default: begin
      end
    endcase

    out_nxt.granted        = granted;
    out_nxt.region_offset  = cra_pkg::ROFF_W'(offset);
    out_nxt.used_bytes     = cra_pkg::LEN_W'(used_nxt);
    out_nxt.total_reserved = sum_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r      <= SZ_W'(MAX_BYTES);
      used_r      <= '0;
      wr_off_r    <= '0;
      rd_off_r    <= '0;
      wrap_r      <= OFF_W'(MAX_BYTES - 1);
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (cfg_wr_en) begin
      size_r      <= SZ_W'(cfg_size);
      used_r      <= '0;
      wr_off_r    <= '0;
      rd_off_r    <= '0;
      wrap_r      <= OFF_W'(cfg_size - CW'(1));
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.execute;
      if (cmd.execute) begin
        used_r   <= used_nxt;
        wr_off_r <= wr_off_nxt;
        rd_off_r <= rd_off_nxt;
        wrap_r   <= wrap_nxt;
        sum_r    <= sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r <= in_data;
    end
    if (cmd.execute) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

[design/contiguous_ring_allocator_top.sv]
// ----------------------------------------------------------------------------
// contiguous_ring_allocator_top: bip-buffer style offset allocator.
// Timing: the strobe is high in the cycle after the execute cycle, and busy
//   holds off a new request during that execute cycle. The receiver cannot
//   stall, and a new request is taken while a result shows.
// Reset (rst_n low, synchronous) sets the size to MAX_BYTES, clears the
//   used count, write/read offsets and total, and sets the wrap point to
//   size minus one; a size write does the same with the new size.
// ----------------------------------------------------------------------------
`default_nettype none

module contiguous_ring_allocator_top #(
  parameter int MAX_BYTES = cra_pkg::MAX_BYTES_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // Request channel: a request is taken when start is high and busy is low.
  input  wire logic                      start,
  output logic                           busy,
  input  wire cra_pkg::in_t              in_data,
  // Result channel: out_valid marks a result for exactly one cycle.
  output logic                           out_valid,
  output cra_pkg::out_t                  out_data,
  // Size register write port.
  input  wire logic                      cfg_wr_en,
  input  wire logic [cra_pkg::LEN_W-1:0] cfg_wr_data
);

  cra_pkg::ctrl_cmd_t cmd;

  // The controller captures each request and then runs its execute cycle,
  // during which busy holds off the next request.
  cra_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // The datapath holds all ring bookkeeping. During the execute cycle it
  // evaluates the captured request against the current offsets, updates
  // them and registers the result, which appears on the next cycle.
  cra_datapath #(
    .MAX_BYTES (MAX_BYTES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_valid   (out_valid),
    .out_data    (out_data)
  );

  // An accepted request always moves the controller into its execute cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not enter execute");

  // Without a size write, the next cycle shows the result strobe and busy low.
  a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && !cfg_wr_en) |=> (out_valid && !busy))
    else $error("execute cycle did not produce a single result");

  // A refused request reports neither an offset nor a chunk.
  a_refused_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.granted) |->
      (out_data.region_offset == '0 && out_data.chunk_length == '0))
    else $error("refused request reported an offset or chunk");

endmodule

`default_nettype wire

[dv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the contiguous ring allocator.
// A short table of directed requests and size writes runs first, followed
// by random phases, each of which starts with a new ring size. A request
// accepted by the block is passed through a local predictor of the ring's
// offsets and counts. Every result strobe is compared field by field with
// the oldest expected result.
// ----------------------------------------------------------------------------
module tb_top;

  // Operation code 3 has no meaning in the block; it must change nothing.
  localparam logic [cra_pkg::FUNC_W-1:0] FUNC_NONE = 2'd3;
  localparam int unsigned RING_MAX     = cra_pkg::MAX_BYTES_DEF;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          RAND_PHASES  = 12;
  localparam int          PHASE_ITEMS  = 152;

  logic                       clk         = 1'b0;
  logic                       rst_n       = 1'b0;
  logic                       start       = 1'b0;
  logic                       busy;
  cra_pkg::in_t               in_data     = '0;
  logic                       out_valid;
  cra_pkg::out_t              out_data;
  logic                       cfg_wr_en   = 1'b0;
  logic [cra_pkg::LEN_W-1:0]  cfg_wr_data = '0;

  // These travel with each request. When a directed row carries a
  // hand-written expectation, that expectation replaces the predicted one.
  logic                       typed_row    = 1'b0;
  cra_pkg::out_t              typed_result = '0;

  contiguous_ring_allocator_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Ring predictor: its own copy of the size register and of the offsets.
  // --------------------------------------------------------------------------
  bit [cra_pkg::LEN_W-1:0]  ring_size;
  bit [cra_pkg::LEN_W-1:0]  used_cnt;
  bit [cra_pkg::ROFF_W-1:0] wr_off;
  bit [cra_pkg::ROFF_W-1:0] rd_off;
  bit [cra_pkg::ROFF_W-1:0] wrap_off;
  bit [cra_pkg::SUM_W-1:0]  resv_sum;

  cra_pkg::out_t   pending_results[$];
  int              error_cnt = 0;
  int unsigned     cycle_cnt = 0;

  // The last byte of the ring is only the end mark, so the wrap point
  // starts out at size minus one.
  function automatic void ring_clear();
    used_cnt = '0;
    wr_off   = '0;
    rd_off   = '0;
    wrap_off = cra_pkg::ROFF_W'(ring_size - 1);
    resv_sum = '0;
  endfunction

  // The size register takes values below 2 as 2 and values above the
  // largest ring as the largest ring.
  function automatic bit [cra_pkg::LEN_W-1:0] clamp_size(logic [cra_pkg::LEN_W-1:0] v);
    if (v < 2) return cra_pkg::LEN_W'(2);
    if (v > RING_MAX) return cra_pkg::LEN_W'(RING_MAX);
    return v;
  endfunction

  function automatic cra_pkg::out_t ring_predict(cra_pkg::in_t req);
    int unsigned   len;
    int unsigned   last;
    int unsigned   avail;
    int unsigned   want;
    int unsigned   chunk;
    cra_pkg::out_t res;
    len  = req.length;
    last = ring_size - 1;
    res  = '0;
    case (req.func)
      cra_pkg::FUNC_RESERVE: begin
        // A reserve that does not fit in the free bytes leaves all as is.
        if (used_cnt + len <= ring_size) begin
          if (wr_off <= last && last - wr_off >= len) begin
            res.region_offset = wr_off;
            wr_off = cra_pkg::ROFF_W'(wr_off + len);
          end else begin
            // The tail cannot hold the region: it goes to offset 0 and the
            // old write offset becomes the wrap point. A reserve of the
            // whole ring leaves the write offset at 0.
            wrap_off = wr_off;
            res.region_offset = '0;
            wr_off = (len >= ring_size) ? '0 : cra_pkg::ROFF_W'(len);
          end
          used_cnt = cra_pkg::LEN_W'(used_cnt + len);
          resv_sum = resv_sum + len;
          res.granted = 1'b1;
        end
      end
      cra_pkg::FUNC_RELEASE: begin
        used_cnt = (len >= used_cnt) ? '0 : cra_pkg::LEN_W'(used_cnt - len);
      end
      cra_pkg::FUNC_FETCH: begin
        // Reading restarts at 0 once the read offset reaches the wrap point.
        if (rd_off >= wrap_off) begin
          rd_off   = '0;
          wrap_off = cra_pkg::ROFF_W'(last);
        end
        avail = wrap_off - rd_off;
        if (used_cnt != 0) begin
          want  = (used_cnt > len) ? len : used_cnt;
          chunk = (avail >= want) ? want : avail;
          res.region_offset = rd_off;
          res.chunk_length  = cra_pkg::LEN_W'(chunk);
          rd_off = cra_pkg::ROFF_W'(rd_off + chunk);
          res.granted = 1'b1;
        end
      end
      default: ;
    endcase
    res.used_bytes     = used_cnt;
    res.total_reserved = resv_sum;
    return res;
  endfunction

  task automatic log_error(string msg);
    error_cnt++;
    if (error_cnt <= 40) $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic check_result(cra_pkg::out_t got, cra_pkg::out_t exp);
    if (got.granted !== exp.granted)
      log_error($sformatf("granted %0d, expected %0d", got.granted, exp.granted));
    if (got.region_offset !== exp.region_offset)
      log_error($sformatf("region_offset %0d, expected %0d",
                          got.region_offset, exp.region_offset));
    if (got.chunk_length !== exp.chunk_length)
      log_error($sformatf("chunk_length %0d, expected %0d",
                          got.chunk_length, exp.chunk_length));
    if (got.used_bytes !== exp.used_bytes)
      log_error($sformatf("used_bytes %0d, expected %0d", got.used_bytes, exp.used_bytes));
    if (got.total_reserved !== exp.total_reserved)
      log_error($sformatf("total_reserved %0d, expected %0d",
                          got.total_reserved, exp.total_reserved));
  endtask

  // --------------------------------------------------------------------------
  // Monitor. All handshake signals are read at the clock edge and so carry
  // their values from before the edge, whichever process runs first.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    cra_pkg::out_t want;
    if (!rst_n) begin
      ring_size = cra_pkg::LEN_W'(RING_MAX);
      ring_clear();
      pending_results.delete();
    end else begin
      if (cfg_wr_en) begin
        ring_size = clamp_size(cfg_wr_data);
        ring_clear();
      end
      if (start && busy === 1'b0) begin
        // The predictor always runs, so its state stays in step even when a
        // hand-written expectation is checked in its place.
        want = ring_predict(in_data);
        pending_results.push_back(typed_row ? typed_result : want);
      end
      if (out_valid === 1'b1) begin
        if (pending_results.size() == 0) begin
          log_error("result strobe with no request outstanding");
        end else begin
          want = pending_results.pop_front();
          check_result(out_data, want);
        end
      end
    end
  end

  // A hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Driver.
  // --------------------------------------------------------------------------

  // Raises start with the request and waits for the edge that takes it, then,
  // if may_idle is set, may lower start and idle. The caller then drives the next
  // request or lowers start in that step, so start is never assigned twice in one step.
  task automatic send_request(logic [cra_pkg::FUNC_W-1:0] op,
                              logic [cra_pkg::LEN_W-1:0] len,
                              bit typed, cra_pkg::out_t exp, bit may_idle);
    start        <= 1'b1;
    in_data      <= '{func: op, length: len};
    typed_row    <= typed;
    typed_result <= exp;
    do @(posedge clk); while (busy !== 1'b0);
    if (may_idle && $urandom_range(0, 99) < 25) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // The size register is only written while the block is idle: every
  // outstanding result has arrived and a few extra cycles have passed.
  task automatic write_size(logic [cra_pkg::LEN_W-1:0] v);
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Random lengths are mostly sized to the ring so that reserves succeed and
  // the wrap logic gets exercised, with some full-width noise and edge values.
  function automatic logic [cra_pkg::LEN_W-1:0] pick_length(int unsigned sz);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return cra_pkg::LEN_W'($urandom_range(0, (1 << cra_pkg::LEN_W) - 1));
    if (r < 20) begin
      case ($urandom_range(0, 4))
        0:       return '0;
        1:       return cra_pkg::LEN_W'(1);
        2:       return cra_pkg::LEN_W'(sz - 1);
        3:       return cra_pkg::LEN_W'(sz + 1);
        default: return cra_pkg::LEN_W'(sz);
      endcase
    end
    if (r < 60) return cra_pkg::LEN_W'($urandom_range(0, (sz / 4 > 1) ? sz / 4 : 1));
    return cra_pkg::LEN_W'($urandom_range(0, sz));
  endfunction

  // Directed table: a size write or a request, optionally with the result
  // written out by hand.
  typedef struct {
    bit                         is_cfg;
    logic [cra_pkg::FUNC_W-1:0] op;
    logic [cra_pkg::LEN_W-1:0]  arg;
    bit                         typed;
    cra_pkg::out_t              exp;
  } step_row_t;

  step_row_t dir_rows[$];

  task automatic add_row(bit is_cfg, logic [cra_pkg::FUNC_W-1:0] op, int unsigned arg,
                         bit typed, bit g, int unsigned off, int unsigned chunk,
                         int unsigned used, int unsigned sum);
    step_row_t row;
    row.is_cfg = is_cfg;
    row.op     = op;
    row.arg    = cra_pkg::LEN_W'(arg);
    row.typed  = typed;
    row.exp    = '{granted: g,
                   region_offset: cra_pkg::ROFF_W'(off),
                   chunk_length: cra_pkg::LEN_W'(chunk),
                   used_bytes: cra_pkg::LEN_W'(used),
                   total_reserved: cra_pkg::SUM_W'(sum)};
    dir_rows.push_back(row);
  endtask

  initial begin
    logic [cra_pkg::FUNC_W-1:0] op;
    logic [cra_pkg::LEN_W-1:0]  cfg_val;
    int unsigned                sz;
    int unsigned                r;
    int                         item_no;
    bit                         steady;

    // Ring of the largest size after reset.
    add_row(0, cra_pkg::FUNC_FETCH,   5,       1, 0, 0, 0, 0,     0);      // nothing used
    add_row(0, cra_pkg::FUNC_RESERVE, 0,       1, 1, 0, 0, 0,     0);      // zero-length
    add_row(0, FUNC_NONE,             'h1FFFF, 1, 0, 0, 0, 0,     0);
    add_row(0, cra_pkg::FUNC_RESERVE, 65537,   1, 0, 0, 0, 0,     0);      // too large
    add_row(0, cra_pkg::FUNC_RESERVE, 65536,   1, 1, 0, 0, 65536, 65536);  // whole ring
    add_row(0, cra_pkg::FUNC_FETCH,   'h1FFFF, 0, 0, 0, 0, 0,     0);      // wrap restart
    add_row(0, cra_pkg::FUNC_FETCH,   0,       0, 0, 0, 0, 0,     0);      // zero-length
    add_row(0, FUNC_NONE,             0,       1, 0, 0, 0, 65536, 65536);
    add_row(0, cra_pkg::FUNC_RELEASE, 'h1FFFF, 1, 0, 0, 0, 0,     65536);  // saturating
    add_row(0, cra_pkg::FUNC_RELEASE, 1,       1, 0, 0, 0, 0,     65536);
    // Smallest ring: two bytes, one of them the end mark.
    add_row(1, FUNC_NONE,             0,       0, 0, 0, 0, 0,     0);
    add_row(0, cra_pkg::FUNC_RESERVE, 1,       0, 0, 0, 0, 0,     0);
    add_row(0, cra_pkg::FUNC_RESERVE, 2,       1, 0, 0, 0, 1,     1);
    add_row(0, cra_pkg::FUNC_RESERVE, 1,       0, 0, 0, 0, 0,     0);
    add_row(0, cra_pkg::FUNC_FETCH,   2,       0, 0, 0, 0, 0,     0);
    add_row(0, cra_pkg::FUNC_FETCH,   2,       0, 0, 0, 0, 0,     0);
    add_row(0, cra_pkg::FUNC_RELEASE, 2,       1, 0, 0, 0, 0,     2);
    add_row(0, cra_pkg::FUNC_FETCH,   3,       1, 0, 0, 0, 0,     2);
    // Oversized write clamps to the largest ring; fill it up to the end mark, then wrap.
    add_row(1, FUNC_NONE,             'h1FFFF, 0, 0, 0, 0, 0,     0);
    add_row(0, cra_pkg::FUNC_RESERVE, 'hFFFF,  0, 0, 0, 0, 0,     0);
    add_row(0, cra_pkg::FUNC_RESERVE, 1,       0, 0, 0, 0, 0,     0);
    add_row(0, cra_pkg::FUNC_FETCH,   'h10000, 0, 0, 0, 0, 0,     0);
    add_row(0, cra_pkg::FUNC_FETCH,   'h10000, 0, 0, 0, 0, 0,     0);
    add_row(1, FUNC_NONE,             1,       0, 0, 0, 0, 0,     0);
    add_row(1, FUNC_NONE,             2,       0, 0, 0, 0, 0,     0);
    add_row(0, cra_pkg::FUNC_FETCH,   0,       1, 0, 0, 0, 0,     0);
    add_row(1, FUNC_NONE,             65536,   0, 0, 0, 0, 0,     0);
    add_row(0, cra_pkg::FUNC_RESERVE, 'h1FFFF, 1, 0, 0, 0, 0,     0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[k]) begin
      if (dir_rows[k].is_cfg)
        write_size(dir_rows[k].arg);
      else
        send_request(dir_rows[k].op, dir_rows[k].arg, dir_rows[k].typed,
                     dir_rows[k].exp, 1'b1);
    end

    // Random phases. Each one starts from a cleared ring of a new size,
    // mostly small so that the wrap point is crossed often.
    item_no = 0;
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0:       cfg_val = cra_pkg::LEN_W'(3);
        1:       cfg_val = cra_pkg::LEN_W'(RING_MAX);
        2:       cfg_val = cra_pkg::LEN_W'($urandom_range(0, (1 << cra_pkg::LEN_W) - 1));
        default: begin
          case ($urandom_range(0, 2))
            0:       cfg_val = cra_pkg::LEN_W'($urandom_range(2, 16));
            1:       cfg_val = cra_pkg::LEN_W'($urandom_range(17, 400));
            default: cfg_val = cra_pkg::LEN_W'($urandom_range(401,
                                                (1 << cra_pkg::LEN_W) - 1));
          endcase
        end
      endcase
      write_size(cfg_val);
      sz = clamp_size(cfg_val);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        r = $urandom_range(0, 99);
        if (r < 40)      op = cra_pkg::FUNC_RESERVE;
        else if (r < 65) op = cra_pkg::FUNC_RELEASE;
        else if (r < 95) op = cra_pkg::FUNC_FETCH;
        else             op = FUNC_NONE;
        // One long stretch runs with no random sender gaps, apart from size writes.
        steady = (item_no >= 700 && item_no < 1100);
        send_request(op, pick_length(sz), 1'b0, '0, !steady);
        item_no++;
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_cnt == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

[files.f]
design/cra_pkg.sv
design/cra_ctrl.sv
design/cra_datapath.sv
design/contiguous_ring_allocator_top.sv
dv/tb_top.sv
